// ===== design/swmf_pkg.sv =====
// Package of the square window median filter: request types, register indexes,
// state encoding and default sizes. It depends on nothing else.
`default_nettype none
package swmf_pkg;

    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 4096;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_MAX_RADIUS   = 2;

    localparam int CFG_WIDTH_W    = 11;
    localparam int CFG_HEIGHT_W   = 13;
    localparam int CFG_CHANNELS_W = 3;
    localparam int CFG_RADIUS_W   = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [CFG_WIDTH_W-1:0]    RST_WIDTH    = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0]   RST_HEIGHT   = 13'd480;
    localparam logic [CFG_CHANNELS_W-1:0] RST_CHANNELS = 3'd1;
    localparam logic [CFG_RADIUS_W-1:0]   RST_RADIUS   = 2'd1;

    localparam int SAMPLE_W = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2,
        REG_WINDOW_RADIUS = 2'd3
    } t_cfg_index;

    typedef enum logic {
        ACT_PUSH  = 1'b0,
        ACT_DRAIN = 1'b1
    } t_action;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] sample;
    } t_in_req;

    typedef struct packed {
        logic [SAMPLE_W-1:0] median_value;
        logic                end_of_frame;
    } t_out_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP1,
        ST_SETUP2,
        ST_DECIDE,
        ST_DIVA,
        ST_DIVA_WAIT,
        ST_DIVB,
        ST_DIVB_WAIT,
        ST_GATHER,
        ST_SELECT,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

// ===== design/swmf_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Self-contained; used by the filter top level to locate a raster index.
`default_nettype none
module swmf_div #(
    parameter int DIVIDEND_W = 25,
    parameter int DIVISOR_W  = 11
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [DIVIDEND_W-1:0]      o_quotient,
    output logic [DIVISOR_W-1:0]       o_remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVISOR_W:0]    shifted;
    logic                  fits;

    assign shifted = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIVIDEND_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            if (fits) begin
                r_rem <= DIVISOR_W'(shifted - {1'b0, r_dvs});
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy      = r_cnt != '0;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

// ===== design/square_window_median_filter_top.sv =====
// Top level of the square window median filter: line store, sequencer,
// window gather pipeline and bitwise median select. Uses swmf_pkg and swmf_div.
//
//  Channel | Signals                               | Direction
//  input   | i_in_valid, o_in_ready, i_in_req      | samples and drain ticks in
//  output  | o_out_valid, i_out_ready, o_out_req   | medians out
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index,| register writes in
//          | i_cfg_data                            |
//
// A request without a result passes SETUP1, SETUP2 and DECIDE and returns to
// idle; one with a result then gathers the window with one line store read per
// window sample, runs 8 select steps and waits in EMIT until the output is free.
// After a register write the first result adds two divider runs. Reset is
// synchronous and active low; the line store is not cleared. A result waiting
// at the output stalls the next result in EMIT, where no request is accepted.
`default_nettype none
module square_window_median_filter_top #(
    parameter int MAX_WIDTH    = swmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = swmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = swmf_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_RADIUS   = swmf_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire swmf_pkg::t_in_req                    i_in_req,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output swmf_pkg::t_out_req                        o_out_req,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [swmf_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [swmf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int DEPTH   = (2 * MAX_RADIUS + 1) * MAX_WIDTH * MAX_CHANNELS;
    localparam int A_W     = $clog2(DEPTH);
    localparam int IDX_W   = $clog2(MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS + 1);
    localparam int X_W     = $clog2(MAX_WIDTH + 1);
    localparam int Y_W     = $clog2(MAX_HEIGHT + 1);
    localparam int C_W     = $clog2(MAX_CHANNELS + 1);
    localparam int R_W     = $clog2(MAX_RADIUS + 1);
    localparam int WC_W    = $clog2(MAX_WIDTH * MAX_CHANNELS + 1);
    localparam int SIDE_W  = $clog2(2 * MAX_RADIUS + 2);
    localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W   = $clog2(WIN_MAX + 1);
    localparam int WI_W    = $clog2(WIN_MAX);
    localparam int DV_W    = X_W > C_W ? X_W : C_W;
    localparam int BIG_W   = IDX_W > A_W ? IDX_W : A_W;
    localparam int OFF_W   = BIG_W + 2;
    localparam int SW      = swmf_pkg::SAMPLE_W;
    localparam int BIT_W   = $clog2(SW);
    localparam logic signed [OFF_W-1:0] S_ONE   = OFF_W'(1);
    localparam logic signed [OFF_W-1:0] S_DEPTH = OFF_W'(DEPTH);

    swmf_pkg::t_state r_state, n_state;

    logic [swmf_pkg::CFG_WIDTH_W-1:0]    r_cfg_w;
    logic [swmf_pkg::CFG_HEIGHT_W-1:0]   r_cfg_h;
    logic [swmf_pkg::CFG_CHANNELS_W-1:0] r_cfg_c;
    logic [swmf_pkg::CFG_RADIUS_W-1:0]   r_cfg_r;
    logic                                r_dirty;

    logic [X_W-1:0] w_eff;
    logic [Y_W-1:0] h_eff;
    logic [C_W-1:0] c_eff;
    logic [R_W-1:0] r_eff;

    swmf_pkg::t_in_req r_req;
    logic [X_W+Y_W-1:0] r_wh;
    logic [WC_W-1:0]    r_wc;
    logic [CNT_W-1:0]   r_n;
    logic [IDX_W-1:0]   r_total;
    logic [IDX_W-1:0]   r_delay;

    logic [IDX_W-1:0] r_in_idx;
    logic [IDX_W-1:0] r_out_idx;
    logic [A_W-1:0]   r_wptr;
    logic [A_W-1:0]   r_optr;
    logic [C_W-1:0]   r_och;
    logic [X_W-1:0]   r_ox;
    logic [Y_W-1:0]   r_oy;
    logic [IDX_W-1:0] r_p;

    logic             cnt_clear;
    logic [IDX_W-1:0] e_in;
    logic [IDX_W-1:0] e_out;
    logic             do_write;
    logic             do_emit;

    logic [SW-1:0]  mem [DEPTH];
    logic           mem_we;
    logic [A_W-1:0] wr_addr;

    logic [SIDE_W-1:0]        r_iy;
    logic [SIDE_W-1:0]        r_ix;
    logic                     r_issuing;
    logic                     r_s1_v;
    logic signed [OFF_W-1:0]  r_s1_off;
    logic                     r_s2_v;
    logic [A_W-1:0]           r_rd_addr;
    logic                     r_s3_v;
    logic [SW-1:0]            r_rd_data;
    logic [CNT_W-1:0]         r_wcnt;
    logic [SW-1:0]            r_win [WIN_MAX];
    logic [SIDE_W-1:0]        side_last;
    logic                     gather_done;

    logic signed [OFF_W-1:0] oy_s, ox_s, dy_s, dx_s, yy_s, xx_s, h_s, w_s;
    logic signed [OFF_W-1:0] dyc, dxc, wc_s, c_s, off, asum, afix;

    logic [WIN_MAX-1:0] r_cand;
    logic [WIN_MAX-1:0] zeros;
    logic [WIN_MAX-1:0] ones;
    logic [CNT_W-1:0]   zcnt;
    logic [CNT_W-1:0]   r_k;
    logic [BIT_W-1:0]   r_bit;
    logic [SW-1:0]      r_med;
    logic               take_zero;

    logic               div_start;
    logic [IDX_W-1:0]   div_dividend;
    logic [DV_W-1:0]    div_divisor;
    logic               div_busy;
    logic [IDX_W-1:0]   div_quo;
    logic [DV_W-1:0]    div_rem;

    logic               r_out_valid;
    swmf_pkg::t_out_req r_out_req;
    logic               out_load;
    logic               last_out;

    assign w_eff = (r_cfg_w == '0) ? X_W'(1)
                 : (32'(r_cfg_w) > MAX_WIDTH) ? X_W'(MAX_WIDTH) : X_W'(r_cfg_w);
    assign h_eff = (r_cfg_h == '0) ? Y_W'(1)
                 : (32'(r_cfg_h) > MAX_HEIGHT) ? Y_W'(MAX_HEIGHT) : Y_W'(r_cfg_h);
    assign c_eff = (r_cfg_c == '0) ? C_W'(1)
                 : (32'(r_cfg_c) > MAX_CHANNELS) ? C_W'(MAX_CHANNELS) : C_W'(r_cfg_c);
    assign r_eff = (r_cfg_r == '0) ? R_W'(1)
                 : (32'(r_cfg_r) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(r_cfg_r);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= swmf_pkg::RST_WIDTH;
            r_cfg_h <= swmf_pkg::RST_HEIGHT;
            r_cfg_c <= swmf_pkg::RST_CHANNELS;
            r_cfg_r <= swmf_pkg::RST_RADIUS;
        end else if (i_cfg_valid) begin
            case (swmf_pkg::t_cfg_index'(i_cfg_index))
                swmf_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg_w <= i_cfg_data[swmf_pkg::CFG_WIDTH_W-1:0];
                end
                swmf_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg_h <= i_cfg_data[swmf_pkg::CFG_HEIGHT_W-1:0];
                end
                swmf_pkg::REG_CHANNEL_COUNT: begin
                    r_cfg_c <= i_cfg_data[swmf_pkg::CFG_CHANNELS_W-1:0];
                end
                swmf_pkg::REG_WINDOW_RADIUS: begin
                    r_cfg_r <= i_cfg_data[swmf_pkg::CFG_RADIUS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cnt_clear = (r_in_idx > r_total) || (r_out_idx >= r_total);
    assign e_in      = cnt_clear ? '0 : r_in_idx;
    assign e_out     = cnt_clear ? '0 : r_out_idx;
    assign wr_addr   = cnt_clear ? '0 : r_wptr;
    assign do_write  = (r_req.action == swmf_pkg::ACT_PUSH) && (e_in < r_total);
    always_comb begin
        if (r_req.action == swmf_pkg::ACT_PUSH) begin
            do_emit = do_write && ({1'b0, e_in} >= ({1'b0, e_out} + {1'b0, r_delay}));
        end else begin
            do_emit = e_in == r_total;
        end
    end

    assign side_last   = SIDE_W'({r_eff, 1'b0});
    assign gather_done = r_s3_v && (r_wcnt == r_n - CNT_W'(1));
    assign out_load    = (r_state == swmf_pkg::ST_EMIT) && (!r_out_valid || i_out_ready);
    assign last_out    = (r_out_idx + IDX_W'(1)) >= r_total;

    always_comb begin
        n_state = r_state;
        case (r_state)
            swmf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = swmf_pkg::ST_SETUP1;
                end
            end
            swmf_pkg::ST_SETUP1: n_state = swmf_pkg::ST_SETUP2;
            swmf_pkg::ST_SETUP2: n_state = swmf_pkg::ST_DECIDE;
            swmf_pkg::ST_DECIDE: begin
                if (!do_emit) begin
                    n_state = swmf_pkg::ST_IDLE;
                end else if (r_dirty && !cnt_clear) begin
                    n_state = swmf_pkg::ST_DIVA;
                end else begin
                    n_state = swmf_pkg::ST_GATHER;
                end
            end
            swmf_pkg::ST_DIVA: n_state = swmf_pkg::ST_DIVA_WAIT;
            swmf_pkg::ST_DIVA_WAIT: begin
                if (!div_busy) begin
                    n_state = swmf_pkg::ST_DIVB;
                end
            end
            swmf_pkg::ST_DIVB: n_state = swmf_pkg::ST_DIVB_WAIT;
            swmf_pkg::ST_DIVB_WAIT: begin
                if (!div_busy) begin
                    n_state = swmf_pkg::ST_GATHER;
                end
            end
            swmf_pkg::ST_GATHER: begin
                if (gather_done) begin
                    n_state = swmf_pkg::ST_SELECT;
                end
            end
            swmf_pkg::ST_SELECT: begin
                if (r_bit == '0) begin
                    n_state = swmf_pkg::ST_EMIT;
                end
            end
            swmf_pkg::ST_EMIT: begin
                if (out_load) begin
                    n_state = swmf_pkg::ST_IDLE;
                end
            end
            default: n_state = swmf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = r_state == swmf_pkg::ST_IDLE;
        mem_we       = (r_state == swmf_pkg::ST_DECIDE) && do_write;
        div_start    = (r_state == swmf_pkg::ST_DIVA) || (r_state == swmf_pkg::ST_DIVB);
        div_dividend = (r_state == swmf_pkg::ST_DIVA) ? r_out_idx : r_p;
        div_divisor  = (r_state == swmf_pkg::ST_DIVA) ? DV_W'(c_eff) : DV_W'(w_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swmf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    swmf_div #(
        .DIVIDEND_W (IDX_W),
        .DIVISOR_W  (DV_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_busy      (div_busy),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == swmf_pkg::ST_IDLE && i_in_valid) begin
            r_req <= i_in_req;
        end
        if (r_state == swmf_pkg::ST_SETUP1) begin
            r_wh <= (X_W+Y_W)'(w_eff * h_eff);
            r_wc <= WC_W'(w_eff * c_eff);
            r_n  <= CNT_W'({r_eff, 1'b1} * {r_eff, 1'b1});
        end
        if (r_state == swmf_pkg::ST_SETUP2) begin
            r_delay <= IDX_W'(r_eff * r_wc + r_eff * c_eff);
        end
        if (r_state == swmf_pkg::ST_DIVA_WAIT && !div_busy) begin
            r_p <= div_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (r_state == swmf_pkg::ST_SETUP2) begin
            r_total <= IDX_W'(r_wh * c_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= r_req.sample;
        end
        r_rd_data <= mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_idx  <= '0;
            r_out_idx <= '0;
            r_wptr    <= '0;
            r_optr    <= '0;
            r_och     <= '0;
            r_ox      <= '0;
            r_oy      <= '0;
            r_dirty   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dirty <= 1'b1;
            end
            case (r_state)
                swmf_pkg::ST_DECIDE: begin
                    if (cnt_clear) begin
                        r_out_idx <= '0;
                        r_optr    <= '0;
                        r_och     <= '0;
                        r_ox      <= '0;
                        r_oy      <= '0;
                        r_dirty   <= i_cfg_valid;
                    end
                    if (do_write) begin
                        r_in_idx <= e_in + IDX_W'(1);
                        if (cnt_clear) begin
                            r_wptr <= A_W'(1);
                        end else if (r_wptr == A_W'(DEPTH - 1)) begin
                            r_wptr <= '0;
                        end else begin
                            r_wptr <= r_wptr + A_W'(1);
                        end
                    end else if (cnt_clear) begin
                        r_in_idx <= '0;
                        r_wptr   <= '0;
                    end
                end
                swmf_pkg::ST_DIVA_WAIT: begin
                    if (!div_busy) begin
                        r_och <= C_W'(div_rem);
                    end
                end
                swmf_pkg::ST_DIVB_WAIT: begin
                    if (!div_busy) begin
                        r_ox    <= X_W'(div_rem);
                        r_oy    <= Y_W'(div_quo);
                        r_dirty <= i_cfg_valid;
                    end
                end
                swmf_pkg::ST_EMIT: begin
                    if (out_load) begin
                        if (last_out) begin
                            r_in_idx  <= '0;
                            r_out_idx <= '0;
                            r_wptr    <= '0;
                            r_optr    <= '0;
                            r_och     <= '0;
                            r_ox      <= '0;
                            r_oy      <= '0;
                        end else begin
                            r_out_idx <= r_out_idx + IDX_W'(1);
                            if (r_optr == A_W'(DEPTH - 1)) begin
                                r_optr <= '0;
                            end else begin
                                r_optr <= r_optr + A_W'(1);
                            end
                            if (r_och == c_eff - C_W'(1)) begin
                                r_och <= '0;
                                if (r_ox == w_eff - X_W'(1)) begin
                                    r_ox <= '0;
                                    r_oy <= r_oy + Y_W'(1);
                                end else begin
                                    r_ox <= r_ox + X_W'(1);
                                end
                            end else begin
                                r_och <= r_och + C_W'(1);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        oy_s = $signed(OFF_W'(r_oy));
        ox_s = $signed(OFF_W'(r_ox));
        h_s  = $signed(OFF_W'(h_eff));
        w_s  = $signed(OFF_W'(w_eff));
        dy_s = $signed(OFF_W'(r_iy)) - $signed(OFF_W'(r_eff));
        dx_s = $signed(OFF_W'(r_ix)) - $signed(OFF_W'(r_eff));
        yy_s = oy_s + dy_s;
        xx_s = ox_s + dx_s;
        if (yy_s < 0) begin
            dyc = -oy_s;
        end else if (yy_s >= h_s) begin
            dyc = h_s - S_ONE - oy_s;
        end else begin
            dyc = dy_s;
        end
        if (xx_s < 0) begin
            dxc = -ox_s;
        end else if (xx_s >= w_s) begin
            dxc = w_s - S_ONE - ox_s;
        end else begin
            dxc = dx_s;
        end
        wc_s = $signed(OFF_W'(r_wc));
        c_s  = $signed(OFF_W'(c_eff));
        off  = dyc * wc_s + dxc * c_s;
        asum = $signed(OFF_W'(r_optr)) + r_s1_off;
        if (asum < 0) begin
            afix = asum + S_DEPTH;
        end else if (asum >= S_DEPTH) begin
            afix = asum - S_DEPTH;
        end else begin
            afix = asum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
        end else begin
            r_s1_v <= (r_state == swmf_pkg::ST_GATHER) && r_issuing;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            if (r_state == swmf_pkg::ST_DECIDE) begin
                r_issuing <= 1'b1;
            end else if (r_state == swmf_pkg::ST_GATHER && r_issuing
                         && r_iy == side_last && r_ix == side_last) begin
                r_issuing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == swmf_pkg::ST_DECIDE) begin
            r_iy   <= '0;
            r_ix   <= '0;
            r_wcnt <= '0;
        end else if (r_state == swmf_pkg::ST_GATHER) begin
            if (r_issuing) begin
                if (r_ix == side_last) begin
                    r_ix <= '0;
                    r_iy <= r_iy + SIDE_W'(1);
                end else begin
                    r_ix <= r_ix + SIDE_W'(1);
                end
            end
            if (r_s3_v) begin
                r_win[r_wcnt[WI_W-1:0]] <= r_rd_data;
                r_wcnt <= r_wcnt + CNT_W'(1);
            end
        end
        r_s1_off  <= off;
        r_rd_addr <= A_W'(afix);
    end

    always_comb begin
        for (int i = 0; i < WIN_MAX; i++) begin
            zeros[i] = r_cand[i] & ~r_win[i][r_bit];
            ones[i]  = r_cand[i] & r_win[i][r_bit];
        end
        zcnt = '0;
        for (int i = 0; i < WIN_MAX; i++) begin
            zcnt = zcnt + CNT_W'(zeros[i]);
        end
        take_zero = r_k < zcnt;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == swmf_pkg::ST_GATHER && gather_done) begin
            for (int i = 0; i < WIN_MAX; i++) begin
                r_cand[i] <= CNT_W'(i) < r_n;
            end
            r_k   <= r_n >> 1;
            r_bit <= BIT_W'(SW - 1);
            r_med <= '0;
        end else if (r_state == swmf_pkg::ST_SELECT) begin
            r_bit <= r_bit - BIT_W'(1);
            if (take_zero) begin
                r_cand <= zeros;
                r_med  <= {r_med[SW-2:0], 1'b0};
            end else begin
                r_cand <= ones;
                r_k    <= r_k - zcnt;
                r_med  <= {r_med[SW-2:0], 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_req.median_value <= r_med;
            r_out_req.end_of_frame <= last_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule
`default_nettype wire
